@@ design/four_level_page_table_walker_unit_macros.svh @@
// Assertion macros for the page table walker. Each macro checks an
// implication on the rising edge of clk, with the check held off in reset.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FPW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define FPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define FPW_ASSERT_IMPL(label, ante, cons)
`define FPW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/fpw_pkg.sv @@
package fpw_pkg;

    localparam int WORD_W    = 64;
    localparam int PHYS_W    = 52;
    localparam int VIRT_W    = 48;
    localparam int MIDX_W    = 14;
    localparam int IDX_W     = 9;
    localparam int OFFSET_W  = 12;
    // Word base of a table: a 64-bit entry shifted right by three.
    localparam int BASE_W    = 61;
    // Word base plus index, with room for the carry.
    localparam int SUM_W     = 62;

    localparam int LVL0_SHIFT = 39;
    localparam int LVL1_SHIFT = 30;
    localparam int LVL2_SHIFT = 21;
    localparam int LVL3_SHIFT = 12;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_LARGE_BIT   = 7;

    localparam logic [WORD_W-1:0] MASK_RESET = 64'h000F_FFFF_FFFF_F000;

    typedef enum logic [1:0] {
        LVL_TOP    = 2'd0,
        LVL_SECOND = 2'd1,
        LVL_THIRD  = 2'd2,
        LVL_LEAF   = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_XLATE = 2'd1,
        OP_UNMAP = 2'd2,
        OP_SETFL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_READ,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    typedef struct packed {
        logic idle;
        logic fin;
    } seq_status_t;

    typedef struct packed {
        logic              ok;
        logic [PHYS_W-1:0] phys_addr;
        logic [WORD_W-1:0] leaf_flags;
    } res_t;

endpackage

@@ design/fpw_table_mem.sv @@
module fpw_table_mem
    import fpw_pkg::*;
#(
    parameter int MEM_WORDS = 16384,
    parameter int AW        = $clog2(MEM_WORDS)
)
(
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    // Single port: one write or one read per cycle, read data registered.
    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/fpw_addr_unit.sv @@
module fpw_addr_unit
    import fpw_pkg::*;
#(
    parameter int MEM_WORDS = 16384,
    parameter int AW        = $clog2(MEM_WORDS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [BASE_W-1:0] base_word,
    input  logic [MIDX_W-1:0] offset,
    output logic              done,
    output logic [AW-1:0]     addr
);

    localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

    logic [SUM_W-1:0] sum;

    assign sum = SUM_W'(base_word) + SUM_W'(offset);

    generate
        if (POW2)
        begin : g_mask
            // The word index wraps by dropping the high bits.
            assign done = start;
            assign addr = sum[AW-1:0];
        end
        else
        begin : g_recip
            // Reciprocal reduction: the quotient estimate floor(sum * RECIP / 2^62) is
            // at most one short, so one compare and subtract finishes the remainder.
            // A single 31 by 27 bit multiplier is shared over five steps.
            localparam int XL_W  = 31;
            localparam int RL_W  = 27;
            localparam int RH_W  = 26;
            localparam int PP_W  = XL_W + RL_W;
            localparam int ACC_W = 64;
            localparam int GAP   = XL_W - RL_W;
            localparam int QSH   = SUM_W - XL_W - RL_W;
            localparam logic [63:0]     RECIP     = (64'h1 << SUM_W) / 64'(MEM_WORDS);
            localparam logic [RL_W-1:0] RECIP_LO  = RECIP[RL_W-1:0];
            localparam logic [RH_W-1:0] RECIP_HI  = RECIP[RL_W +: RH_W];
            localparam logic [2:0]      LAST_STEP = 3'd5;

            logic             busy_reg;
            logic [2:0]       step_reg;
            logic [SUM_W-1:0] x_reg;
            logic [ACC_W-1:0] acc_reg;
            logic [AW:0]      rem_reg;
            logic [AW:0]      rem_fix;
            logic [XL_W-1:0]  mul_a;
            logic [RL_W-1:0]  mul_b;
            logic [PP_W-1:0]  prod;

            // Steps 0 to 3 form the partial products of sum * RECIP, low half
            // first; step 4 multiplies the quotient back by the depth.
            always_comb
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = x_reg[XL_W-1:0];
                        mul_b = RECIP_LO;
                    end
                    3'd1:
                    begin
                        mul_a = x_reg[XL_W-1:0];
                        mul_b = RL_W'(RECIP_HI);
                    end
                    3'd2:
                    begin
                        mul_a = x_reg[SUM_W-1:XL_W];
                        mul_b = RECIP_LO;
                    end
                    3'd3:
                    begin
                        mul_a = x_reg[SUM_W-1:XL_W];
                        mul_b = RL_W'(RECIP_HI);
                    end
                    3'd4:
                    begin
                        mul_a = XL_W'(acc_reg[QSH +: AW+1]);
                        mul_b = RL_W'(MEM_WORDS);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end

            assign prod = PP_W'(mul_a) * PP_W'(mul_b);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
                else if (busy_reg)
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    x_reg <= sum;
                end
                else if (busy_reg)
                begin
                    case (step_reg)
                        3'd0:    acc_reg <= ACC_W'(prod);
                        3'd1:    acc_reg <= (acc_reg >> RL_W) + ACC_W'(prod);
                        3'd2:    acc_reg <= acc_reg + (ACC_W'(prod) << GAP);
                        3'd3:    acc_reg <= (acc_reg >> XL_W) + ACC_W'(prod);
                        3'd4:    rem_reg <= x_reg[AW:0] - prod[AW:0];
                        default: ;
                    endcase
                end
            end

            assign rem_fix = (rem_reg >= (AW+1)'(MEM_WORDS))
                           ? rem_reg - (AW+1)'(MEM_WORDS) : rem_reg;
            assign done    = busy_reg && (step_reg == LAST_STEP);
            assign addr    = rem_fix[AW-1:0];
        end
    endgenerate

endmodule

@@ design/fpw_walk_ctrl.sv @@
module fpw_walk_ctrl
    import fpw_pkg::*;
#(
    parameter int MEM_WORDS = 16384,
    parameter int AW        = $clog2(MEM_WORDS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  logic [1:0]        op,
    input  logic [PHYS_W-1:0] root,
    input  logic [VIRT_W-1:0] virt,
    input  logic [WORD_W-1:0] new_flags,
    input  logic [MIDX_W-1:0] mem_index,
    input  logic [WORD_W-1:0] mem_data,
    input  logic [WORD_W-1:0] address_mask,
    output logic              unit_start,
    output logic [BASE_W-1:0] unit_base,
    output logic [MIDX_W-1:0] unit_offset,
    input  logic              unit_done,
    input  logic [AW-1:0]     unit_addr,
    output mem_ctl_t          mem_ctl,
    output logic [AW-1:0]     mem_addr,
    output logic [WORD_W-1:0] mem_wdata,
    input  logic [WORD_W-1:0] rd_data,
    output seq_status_t       status,
    output res_t              res,
    input  logic              res_take
);

    seq_state_t        state_reg, state_next;
    level_t            level_reg, level_next;
    level_t            level_succ;
    logic [AW-1:0]     addr_reg, addr_next;
    res_t              res_reg, res_next;
    op_t               op_reg;
    logic [PHYS_W-1:0] root_reg;
    logic [VIRT_W-1:0] virt_reg;
    logic [WORD_W-1:0] new_flags_reg;
    logic [MIDX_W-1:0] mem_index_reg;
    logic [WORD_W-1:0] mem_data_reg;
    logic [WORD_W-1:0] entry_masked;
    logic              walk_fail;
    logic              issue_addr;

    function automatic logic [IDX_W-1:0] level_index(input logic [VIRT_W-1:0] v,
                                                      input level_t l);
        case (l)
            LVL_TOP:    level_index = v[LVL0_SHIFT +: IDX_W];
            LVL_SECOND: level_index = v[LVL1_SHIFT +: IDX_W];
            LVL_THIRD:  level_index = v[LVL2_SHIFT +: IDX_W];
            LVL_LEAF:   level_index = v[LVL3_SHIFT +: IDX_W];
            default:    level_index = '0;
        endcase
    endfunction

    assign level_succ   = level_t'(level_reg + 2'd1);
    assign entry_masked = rd_data & address_mask;
    // Absent entry at any level, or a large page at the second or third level.
    assign walk_fail = !rd_data[ENTRY_PRESENT_BIT]
                     || ((level_reg == LVL_SECOND || level_reg == LVL_THIRD)
                         && rd_data[ENTRY_LARGE_BIT]);

    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        addr_next   = addr_reg;
        res_next    = res_reg;
        unit_start  = 1'b0;
        unit_base   = '0;
        unit_offset = '0;
        issue_addr  = 1'b0;
        mem_ctl     = '0;
        mem_addr    = addr_reg;
        mem_wdata   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_START;
                    level_next = LVL_TOP;
                end
            end
            ST_START:
            begin
                unit_start = 1'b1;
                if (op_reg == OP_WRITE)
                begin
                    unit_offset = mem_index_reg;
                end
                else
                begin
                    unit_base   = BASE_W'(root_reg[PHYS_W-1:3]);
                    unit_offset = MIDX_W'(level_index(virt_reg, LVL_TOP));
                end
                if (unit_done)
                begin
                    issue_addr = 1'b1;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    issue_addr = 1'b1;
                end
            end
            ST_READ:
            begin
                if (walk_fail)
                begin
                    res_next   = '0;
                    state_next = ST_FINISH;
                end
                else if (level_reg == LVL_LEAF)
                begin
                    res_next    = '0;
                    res_next.ok = 1'b1;
                    state_next  = ST_FINISH;
                    case (op_reg)
                        OP_XLATE:
                        begin
                            res_next.phys_addr  = entry_masked[PHYS_W-1:0]
                                                | PHYS_W'(virt_reg[OFFSET_W-1:0]);
                            res_next.leaf_flags = rd_data & ~address_mask;
                        end
                        OP_UNMAP:
                        begin
                            mem_ctl.we = 1'b1;
                        end
                        OP_SETFL:
                        begin
                            mem_ctl.we = 1'b1;
                            mem_wdata  = entry_masked | new_flags_reg;
                            mem_wdata[ENTRY_LARGE_BIT]   = 1'b0 | entry_masked[ENTRY_LARGE_BIT];
                            mem_wdata[ENTRY_PRESENT_BIT] = 1'b1;
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
                else
                begin
                    level_next  = level_succ;
                    unit_start  = 1'b1;
                    unit_base   = entry_masked[WORD_W-1:3];
                    unit_offset = MIDX_W'(level_index(virt_reg, level_succ));
                    if (unit_done)
                    begin
                        issue_addr = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A word address is ready: write the word, or fetch the next entry.
        if (issue_addr)
        begin
            addr_next = unit_addr;
            mem_addr  = unit_addr;
            if (op_reg == OP_WRITE)
            begin
                mem_ctl.we  = 1'b1;
                mem_wdata   = mem_data_reg;
                res_next    = '0;
                res_next.ok = 1'b1;
                state_next  = ST_FINISH;
            end
            else
            begin
                mem_ctl.re = 1'b1;
                state_next = ST_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= LVL_TOP;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        res_reg  <= res_next;
        if (in_take)
        begin
            op_reg        <= op_t'(op);
            root_reg      <= root;
            virt_reg      <= virt;
            new_flags_reg <= new_flags;
            mem_index_reg <= mem_index;
            mem_data_reg  <= mem_data;
        end
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.fin  = (state_reg == ST_FINISH);
    assign res         = res_reg;

endmodule

@@ design/four_level_page_table_walker_unit.sv @@
// Four-level page table walker over a private table memory of MEM_WORDS 64-bit words.
// Each transaction is a memory word write (op 0), or a translate, unmap or set-flags
// walk (ops 1 to 3) that indexes four tables from root with virt[47:39], [38:30],
// [29:21] and [20:12]; a walk fails on an absent entry or on a large-page bit at the
// second or third level, and a failed walk returns ok, phys_addr and leaf_flags as 0.
// One transaction is handled at a time. With MEM_WORDS a power of two, the sequencer
// first forms the top-level word address, then the four table reads follow back to
// back through the single memory port, the leaf update sharing the last of them, the
// result is handed to the output register, and the next transaction is accepted in
// the idle state after that; a memory write is issued as soon as its word address is
// formed. A walk that fails early reads no further tables, and a stalled output
// register holds the sequencer until it drains. With any other MEM_WORDS the word
// address wraps through a reciprocal-multiplication reduction that shares one 31
// by 27 bit multiplier over five steps, and the sequencer waits on it for each of
// the four (or, for a write, the one) address computations. Words never written
// read back undefined, and address_mask must be written by the user through the
// cfg channel only while the block is idle; the block itself does not enforce it.
`include "four_level_page_table_walker_unit_macros.svh"

module four_level_page_table_walker_unit
    import fpw_pkg::*;
#(
    parameter int MEM_WORDS = 16384
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [PHYS_W-1:0] root,
    input  logic [VIRT_W-1:0] virt,
    input  logic [WORD_W-1:0] new_flags,
    input  logic [MIDX_W-1:0] mem_index,
    input  logic [WORD_W-1:0] mem_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [PHYS_W-1:0] phys_addr,
    output logic [WORD_W-1:0] leaf_flags,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [WORD_W-1:0] address_mask_reg;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;
    logic              in_take;
    logic              res_take;
    seq_status_t       status;
    res_t              res;
    logic              unit_start;
    logic [BASE_W-1:0] unit_base;
    logic [MIDX_W-1:0] unit_offset;
    logic              unit_done;
    logic [AW-1:0]     unit_addr;
    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] rd_data;

    // The sequencer takes a new transaction only from its idle state; a result
    // waiting in the output register does not hold it there.
    assign in_stall = !status.idle;
    assign in_take  = in_valid && !in_stall;

    // The mask register can always be written; the user keeps writes to idle time.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_mask_reg <= MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            address_mask_reg <= cfg_data;
        end
    end

    // The sequencer's finished result moves into the output register whenever that
    // register is empty or is being emptied in the same cycle.
    assign res_take = status.fin && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = out_res_reg.ok;
    assign phys_addr  = out_res_reg.phys_addr;
    assign leaf_flags = out_res_reg.leaf_flags;

    // Sequencer: latches the transaction, steps through the levels and decides the
    // outcome of each table read.
    fpw_walk_ctrl #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_take      (in_take),
        .op           (op),
        .root         (root),
        .virt         (virt),
        .new_flags    (new_flags),
        .mem_index    (mem_index),
        .mem_data     (mem_data),
        .address_mask (address_mask_reg),
        .unit_start   (unit_start),
        .unit_base    (unit_base),
        .unit_offset  (unit_offset),
        .unit_done    (unit_done),
        .unit_addr    (unit_addr),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .rd_data      (rd_data),
        .status       (status),
        .res          (res),
        .res_take     (res_take)
    );

    // Shared address unit: table base plus index, wrapped to the memory depth. It
    // serves the write address and all four walk levels.
    fpw_addr_unit #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (unit_start),
        .base_word (unit_base),
        .offset    (unit_offset),
        .done      (unit_done),
        .addr      (unit_addr)
    );

    // Single-ported table memory.
    fpw_table_mem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rd_data)
    );

    // An accepted transaction always sets the sequencer to work.
    `FPW_ASSERT_NEXT(a_accept_starts, in_take, !status.idle)
    // Once a result has been handed over, the sequencer is free for the next one.
    `FPW_ASSERT_NEXT(a_handover_frees, res_take, status.idle)
    // A failed walk never leaks address or flag bits.
    `FPW_ASSERT_IMPL(a_fail_zero, out_valid && !ok, phys_addr == '0 && leaf_flags == '0)
    // The sequencer never writes and reads the memory in the same cycle.
    `FPW_ASSERT_IMPL(a_one_access, mem_ctl.we, !mem_ctl.re)

endmodule

@@ dv/four_level_page_table_walker_unit_tb.sv @@
module four_level_page_table_walker_unit_tb;

    import fpw_pkg::*;

    localparam int MEM_WORDS = 16384;

    // Cycles without any accepted transaction on any channel before the run is
    // abandoned. The slowest correct walk stays well inside this limit even with both
    // sides idling.
    localparam int WATCHDOG_LIMIT = 4000;

    // Cycles left to settle once every expected result has come back.
    localparam int SETTLE_CYCLES = 20;

    localparam logic [WORD_W-1:0] PRESENT_FLAG = 64'h1 << ENTRY_PRESENT_BIT;
    localparam logic [WORD_W-1:0] LARGE_PAGE   = 64'h1 << ENTRY_LARGE_BIT;

    // One request transaction as it sits in the queue ahead of the driver.
    typedef struct packed {
        op_t               op;
        logic [PHYS_W-1:0] root;
        logic [VIRT_W-1:0] virt;
        logic [WORD_W-1:0] new_flags;
        logic [MIDX_W-1:0] mem_index;
        logic [WORD_W-1:0] mem_data;
    } walk_req_t;

    // A mapping that the stimulus has built and may walk again later.
    typedef struct packed {
        logic [PHYS_W-1:0] root;
        logic [VIRT_W-1:0] virt;
    } page_ref_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [1:0]        op         = '0;
    logic [PHYS_W-1:0] root       = '0;
    logic [VIRT_W-1:0] virt       = '0;
    logic [WORD_W-1:0] new_flags  = '0;
    logic [MIDX_W-1:0] mem_index  = '0;
    logic [WORD_W-1:0] mem_data   = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              ok;
    logic [PHYS_W-1:0] phys_addr;
    logic [WORD_W-1:0] leaf_flags;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data   = '0;

    // Shadow of the table memory and of the frame mask register. A word is only
    // ever read by a walk once its written flag is set.
    logic [WORD_W-1:0] table_words  [MEM_WORDS];
    bit                word_written [MEM_WORDS];
    logic [WORD_W-1:0] frame_mask = MASK_RESET;

    walk_req_t queued_requests [$];
    res_t      awaited_results [$];
    page_ref_t mapped_pages    [$];

    walk_req_t   accepted_req;
    res_t        want;
    bit          idle_on = 1'b1;
    int          gap_cycles;
    int          hold_cycles;
    int unsigned issued_items;
    int unsigned failures;
    int unsigned n_writes;
    int unsigned n_xlates;
    int unsigned n_unmaps;
    int unsigned n_setflags;
    int unsigned n_faults;
    int unsigned n_mask_writes;

    four_level_page_table_walker_unit #(
        .MEM_WORDS (MEM_WORDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .root       (root),
        .virt       (virt),
        .new_flags  (new_flags),
        .mem_index  (mem_index),
        .mem_data   (mem_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .phys_addr  (phys_addr),
        .leaf_flags (leaf_flags),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Walk arithmetic shared by the predictor and by the stimulus planner.
    // ------------------------------------------------------------------

    function automatic int level_shift(input int lvl);
        case (level_t'(lvl))
            LVL_TOP:    return LVL0_SHIFT;
            LVL_SECOND: return LVL1_SHIFT;
            LVL_THIRD:  return LVL2_SHIFT;
            default:    return LVL3_SHIFT;
        endcase
    endfunction

    // Entry idx of the table at byte address base. The low three address bits
    // drop out and the word address wraps round the memory.
    function automatic logic [MIDX_W-1:0] word_of(input logic [WORD_W-1:0] base,
                                                  input logic [IDX_W-1:0] idx);
        return MIDX_W'(((base >> 3) + WORD_W'(idx)) % MEM_WORDS);
    endfunction

    // Follows the four levels through the shadow memory. Returns 1 with the leaf
    // word when a present leaf is reached. If the walk would touch a word that
    // has never been written, hole is set and hole_w names that word.
    function automatic bit walk_tables(input logic [PHYS_W-1:0] rt,
                                       input logic [VIRT_W-1:0] va,
                                       output logic [MIDX_W-1:0] leaf_w,
                                       output bit hole,
                                       output logic [MIDX_W-1:0] hole_w);
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] entry;
        logic [MIDX_W-1:0] w;
        base   = WORD_W'(rt);
        hole   = 1'b0;
        hole_w = '0;
        leaf_w = '0;
        w      = '0;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            w = word_of(base, IDX_W'(va >> level_shift(lvl)));
            if (!word_written[w])
            begin
                hole   = 1'b1;
                hole_w = w;
                return 1'b0;
            end
            entry = table_words[w];
            if (!entry[ENTRY_PRESENT_BIT])
                return 1'b0;
            // The large-page bit is only fatal at the two middle levels; at the
            // top it is ignored and at the leaf it is just another flag.
            if ((lvl == int'(LVL_SECOND) || lvl == int'(LVL_THIRD)) && entry[ENTRY_LARGE_BIT])
                return 1'b0;
            base = entry & frame_mask;
        end
        leaf_w = w;
        return 1'b1;
    endfunction

    // The predictor proper: applies one accepted transaction to the shadow state
    // and queues the result that the block must return for it.
    function automatic void walk_and_update(input walk_req_t t);
        res_t              r;
        logic [WORD_W-1:0] leaf;
        logic [MIDX_W-1:0] leaf_w;
        logic [MIDX_W-1:0] hole_w;
        bit                hole;
        r = '0;
        if (t.op == OP_WRITE)
        begin
            table_words[t.mem_index % MEM_WORDS]  = t.mem_data;
            word_written[t.mem_index % MEM_WORDS] = 1'b1;
            r.ok = 1'b1;
            n_writes++;
        end
        else if (walk_tables(t.root, t.virt, leaf_w, hole, hole_w))
        begin
            leaf = table_words[leaf_w];
            r.ok = 1'b1;
            case (t.op)
                OP_XLATE:
                begin
                    r.phys_addr  = PHYS_W'((leaf & frame_mask)
                                           | WORD_W'(t.virt[OFFSET_W-1:0]));
                    r.leaf_flags = leaf & ~frame_mask;
                    n_xlates++;
                end
                OP_UNMAP:
                begin
                    table_words[leaf_w] = '0;
                    n_unmaps++;
                end
                default:
                begin
                    table_words[leaf_w] = (leaf & frame_mask) | (t.new_flags & ~LARGE_PAGE)
                                          | PRESENT_FLAG;
                    n_setflags++;
                end
            endcase
        end
        else
        begin
            // The planner fills every hole before a walk is queued, so reaching
            // an unwritten word here means the stimulus itself went wrong.
            if (hole)
            begin
                $error("walk reached unwritten word %0h", hole_w);
                failures++;
            end
            n_faults++;
        end
        awaited_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. The front of the queue is the transaction on the bus; it
    // is popped and predicted at the edge where it is accepted. Random idle
    // bursts are inserted between transactions.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            gap_cycles = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_req = queued_requests.pop_front();
                walk_and_update(accepted_req);
            end
            if (in_valid && in_stall)
            begin
                // Stalled: the payload and valid stay exactly as they are.
            end
            else if (gap_cycles > 0)
            begin
                gap_cycles--;
                in_valid <= 1'b0;
            end
            else if (queued_requests.size() != 0 && idle_on && $urandom_range(0, 5) == 0)
            begin
                gap_cycles = $urandom_range(0, 6);
                in_valid   <= 1'b0;
            end
            else if (queued_requests.size() != 0)
            begin
                in_valid  <= 1'b1;
                op        <= queued_requests[0].op;
                root      <= queued_requests[0].root;
                virt      <= queued_requests[0].virt;
                new_flags <= queued_requests[0].new_flags;
                mem_index <= queued_requests[0].mem_index;
                mem_data  <= queued_requests[0].mem_data;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, in bursts of the same length as the sender's.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles = 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            hold_cycles = $urandom_range(0, 6);
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every accepted result transaction is compared field by
    // field against the oldest prediction still outstanding.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing outstanding: ok=%0h phys_addr=%0h leaf_flags=%0h",
                       ok, phys_addr, leaf_flags);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok: expected %0h, actual %0h", want.ok, ok);
                    failures++;
                end
                if (phys_addr !== want.phys_addr)
                begin
                    $error("phys_addr: expected %0h, actual %0h", want.phys_addr, phys_addr);
                    failures++;
                end
                if (leaf_flags !== want.leaf_flags)
                begin
                    $error("leaf_flags: expected %0h, actual %0h", want.leaf_flags, leaf_flags);
                    failures++;
                end
            end
        end
    end

    // Watchdog: any accepted transaction on any channel resets the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[four_level_page_table_walker_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PHYS_W-1:0] rand_phys();
        return PHYS_W'({$urandom, $urandom});
    endfunction

    function automatic logic [VIRT_W-1:0] rand_virt();
        return VIRT_W'({$urandom, $urandom});
    endfunction

    // A table entry for filling a hole: usually present, sometimes large.
    function automatic logic [WORD_W-1:0] random_entry();
        logic [WORD_W-1:0] e;
        e = rand_word();
        e[ENTRY_PRESENT_BIT] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 3) != 0)
            e[ENTRY_LARGE_BIT] = 1'b0;
        return e;
    endfunction

    function automatic op_t pick_walk_op();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return OP_XLATE;
        else if (p < 80)
            return OP_SETFL;
        else
            return OP_UNMAP;
    endfunction

    // Memory writes need no planning, so they queue up freely behind each
    // other. The walk fields are still randomised so every bit toggles.
    task automatic push_write(input logic [MIDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        walk_req_t req;
        req.op        = OP_WRITE;
        req.root      = rand_phys();
        req.virt      = rand_virt();
        req.new_flags = rand_word();
        req.mem_index = idx;
        req.mem_data  = data;
        queued_requests.push_back(req);
        issued_items++;
    endtask

    // A walk may only be planned once every earlier transaction has been
    // accepted, so that the shadow memory is exactly what the block will see.
    // Any unwritten word on the path is written first, one level at a time.
    task automatic push_walk(input op_t kind, input logic [PHYS_W-1:0] rt,
                             input logic [VIRT_W-1:0] va, input logic [WORD_W-1:0] flags);
        walk_req_t         req;
        logic [MIDX_W-1:0] leaf_w;
        logic [MIDX_W-1:0] hole_w;
        bit                hole;
        bit                reached;
        do
        begin
            while (queued_requests.size() != 0)
                @(negedge clk);
            reached = walk_tables(rt, va, leaf_w, hole, hole_w);
            if (hole)
                push_write(hole_w, random_entry());
        end
        while (hole);
        req.op        = kind;
        req.root      = rt;
        req.virt      = va;
        req.new_flags = flags;
        req.mem_index = MIDX_W'($urandom);
        req.mem_data  = rand_word();
        queued_requests.push_back(req);
        issued_items++;
    endtask

    // Writes the four entries of a mapping along the path of va from rt, using
    // the current frame mask to follow each entry to the next table.
    task automatic map_entries(input logic [PHYS_W-1:0] rt, input logic [VIRT_W-1:0] va,
                               input logic [3:0][WORD_W-1:0] chain,
                               output logic [3:0][MIDX_W-1:0] words);
        logic [WORD_W-1:0] base;
        base = WORD_W'(rt);
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            words[lvl] = word_of(base, IDX_W'(va >> level_shift(lvl)));
            push_write(words[lvl], chain[lvl]);
            base = chain[lvl] & frame_mask;
        end
    endtask

    // A mapping with random content: mostly well formed, with the occasional
    // absent entry or middle-level large page to break the walk.
    task automatic map_random_page(input logic [PHYS_W-1:0] rt, input logic [VIRT_W-1:0] va);
        logic [3:0][WORD_W-1:0] chain;
        logic [3:0][MIDX_W-1:0] words;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            chain[lvl] = rand_word();
            if (lvl == int'(LVL_LEAF))
                chain[lvl][ENTRY_PRESENT_BIT] = ($urandom_range(0, 7) != 0);
            else
                chain[lvl][ENTRY_PRESENT_BIT] = ($urandom_range(0, 15) != 0);
            if (lvl == int'(LVL_SECOND) || lvl == int'(LVL_THIRD))
                chain[lvl][ENTRY_LARGE_BIT] = ($urandom_range(0, 9) == 0);
        end
        map_entries(rt, va, chain, words);
    endtask

    // Holds the sender until the block has returned everything outstanding.
    task automatic drain();
        while (queued_requests.size() != 0 || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // The mask is only reprogrammed while the block is idle.
    task automatic write_mask(input logic [WORD_W-1:0] value);
        drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        frame_mask = value;
        n_mask_writes++;
    endtask

    // Hand-picked transactions under the reset mask: a clean translation, the
    // large-page bit at the second and third levels, flag update with every
    // flag bit set, unmap and the fault after it, an absent top-level entry,
    // the corner word indices, and a root whose word address wraps round.
    task automatic run_directed();
        logic [PHYS_W-1:0]      root_a;
        logic [PHYS_W-1:0]      root_b;
        logic [VIRT_W-1:0]      virt_a;
        logic [3:0][WORD_W-1:0] chain;
        logic [3:0][MIDX_W-1:0] words;
        page_ref_t              pg;
        root_a = 52'h0_0000_0000_2000;
        virt_a = {9'h1FF, 9'h000, 9'h155, 9'h0AA, 12'hFFF};
        // Top-level entry carries the large-page bit, which must be ignored.
        chain  = {64'hFFF0_0000_1234_5067, 64'h0000_0000_0000_5007,
                  64'h0000_0000_0000_4003, 64'h8000_0000_0000_3081};
        map_entries(root_a, virt_a, chain, words);
        push_walk(OP_XLATE, root_a, virt_a, '0);

        push_write(words[1], chain[1] | LARGE_PAGE);
        push_walk(OP_XLATE, root_a, virt_a, '0);
        push_write(words[1], chain[1]);
        push_write(words[2], chain[2] | LARGE_PAGE);
        push_walk(OP_XLATE, root_a, virt_a, '0);
        push_write(words[2], chain[2]);

        push_walk(OP_SETFL, root_a, virt_a, '1);
        push_walk(OP_XLATE, root_a, {virt_a[VIRT_W-1:OFFSET_W], 12'h000}, '0);
        push_walk(OP_UNMAP, root_a, virt_a, '0);
        push_walk(OP_XLATE, root_a, virt_a, '0);

        // The low three bits of this root fall away in the word address.
        root_b = 52'h0_0000_0000_700F;
        push_write(word_of(WORD_W'(root_b), virt_a[47:39]), 64'hFFFF_FFFF_FFFF_FFFE);
        push_walk(OP_XLATE, root_b, virt_a, '0);

        push_write('1, '1);
        push_write('0, '0);

        map_random_page('1, '1);
        push_walk(OP_XLATE, '1, '1, '0);

        pg.root = root_a;
        pg.virt = virt_a;
        mapped_pages.push_back(pg);
    endtask

    // Random traffic: mostly fresh mappings walked straight away and revisits
    // of earlier ones, with perturbed addresses, stray walks and stray writes
    // mixed in as noise.
    task automatic run_random(input int unsigned count, input bit calm_tail);
        int unsigned start;
        int unsigned pick;
        int unsigned next_toggle;
        bit          paused;
        page_ref_t   pg;
        start       = issued_items;
        next_toggle = issued_items;
        paused      = 1'b0;
        while (issued_items - start < count)
        begin
            if (calm_tail && issued_items - start >= count / 2)
                idle_on = 1'b0;
            else if (issued_items >= next_toggle)
            begin
                idle_on     = ($urandom_range(0, 3) != 0);
                next_toggle = issued_items + 40;
            end
            if (!paused && issued_items - start >= count / 3)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35 || mapped_pages.size() == 0)
            begin
                pg.root = rand_phys();
                pg.virt = rand_virt();
                map_random_page(pg.root, pg.virt);
                mapped_pages.push_back(pg);
                if (mapped_pages.size() > 48)
                    mapped_pages.delete(0);
                push_walk(pick_walk_op(), pg.root, pg.virt, rand_word());
            end
            else if (pick < 65)
            begin
                pg = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
                push_walk(pick_walk_op(), pg.root,
                          {pg.virt[VIRT_W-1:OFFSET_W], OFFSET_W'($urandom)}, rand_word());
            end
            else if (pick < 75)
            begin
                pg = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
                push_walk(pick_walk_op(), pg.root,
                          pg.virt ^ (VIRT_W'(1) << $urandom_range(OFFSET_W, VIRT_W - 1)),
                          rand_word());
            end
            else if (pick < 85)
            begin
                push_walk(pick_walk_op(), rand_phys(), rand_virt(), rand_word());
            end
            else
            begin
                push_write(MIDX_W'($urandom), rand_word());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence: directed checks under the reset mask, then random phases
    // under the reset, all-ones, all-zero, random, narrow and reset masks. Idling
    // is switched off for the second half of the last phase.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(150, 1'b0);

        write_mask('1);
        run_random(120, 1'b0);

        write_mask('0);
        run_random(100, 1'b0);

        write_mask(rand_word());
        run_random(120, 1'b0);

        // Keeps every frame pointer inside the table memory, so walks revisit
        // the same tables far more often.
        write_mask(64'h0000_0000_0001_F000);
        run_random(140, 1'b0);

        write_mask(MASK_RESET);
        run_random(100, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d table writes, %0d translations, %0d unmaps and %0d flag updates,",
                 n_writes, n_xlates, n_unmaps, n_setflags);
        $display("with %0d failed walks over %0d frame mask settings including all-zero and all-one.",
                 n_faults, n_mask_writes + 1);
        if (failures == 0)
            $display("[four_level_page_table_walker_unit] OK");
        else
            $display("[four_level_page_table_walker_unit] ERROR");
        $finish;
    end

endmodule
